>>> sv/iwt_pkg.sv
`timescale 1ns / 1ps

package iwt_pkg;

  localparam int unsigned ValueW    = 31;
  localparam int unsigned CodeW     = 5;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned ConvCntW  = $clog2(ValueW);

  localparam logic [ConvCntW-1:0] ConvLast = ConvCntW'(ValueW - 1);

  localparam logic [CodeW-1:0] WORD_ZERO      = 5'd0;
  localparam logic [CodeW-1:0] WORD_TEEN_BASE = 5'd10;
  localparam logic [CodeW-1:0] WORD_TENS_BASE = 5'd18;
  localparam logic [CodeW-1:0] WORD_HUNDRED   = 5'd28;
  localparam logic [CodeW-1:0] WORD_THOUSAND  = 5'd29;
  localparam logic [CodeW-1:0] WORD_MILLION   = 5'd30;
  localparam logic [CodeW-1:0] WORD_BILLION   = 5'd31;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT,
    S_FLUSH
  } state_e;

  typedef enum logic [2:0] {
    PH_DIGIT,
    PH_HUNDRED,
    PH_TENS,
    PH_ONES,
    PH_SCALE
  } phase_e;

  typedef enum logic [1:0] {
    GRP_BILLION,
    GRP_MILLION,
    GRP_THOUSAND,
    GRP_UNIT
  } group_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic emit_done;
    logic slot_free;
    logic pend_valid;
  } status_t;

endpackage

>>> sv/iwt_in_if.sv
`timescale 1ns / 1ps

interface iwt_in_if;
  logic                          valid;
  logic                          ready;
  logic [iwt_pkg::ValueW-1:0]    value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

>>> sv/iwt_out_if.sv
`timescale 1ns / 1ps

interface iwt_out_if;
  logic                          valid;
  logic                          ready;
  logic [iwt_pkg::CodeW-1:0]     word_code;
  logic                          last_word;

  modport source (output valid, output word_code, output last_word, input ready);
  modport sink (input valid, input word_code, input last_word, output ready);
endinterface

>>> sv/iwt_ctrl.sv
`timescale 1ns / 1ps

module iwt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  iwt_pkg::status_t status_i,
  output logic             in_ready_o,
  output iwt_pkg::cmd_t    cmd_o
);

  iwt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iwt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iwt_pkg::S_IDLE: begin
        if (in_valid_i) state_d = iwt_pkg::S_CONV;
      end
      iwt_pkg::S_CONV: begin
        if (status_i.conv_done) state_d = iwt_pkg::S_EMIT;
      end
      iwt_pkg::S_EMIT: begin
        if (status_i.slot_free && status_i.emit_done) state_d = iwt_pkg::S_FLUSH;
      end
      iwt_pkg::S_FLUSH: begin
        if (status_i.slot_free) state_d = iwt_pkg::S_IDLE;
      end
      default: state_d = iwt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      iwt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      iwt_pkg::S_CONV: begin
        cmd_o.conv_step = 1'b1;
      end
      iwt_pkg::S_EMIT: begin
        cmd_o.emit_step = status_i.slot_free;
      end
      iwt_pkg::S_FLUSH: begin
        cmd_o.flush = status_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> sv/iwt_dpath.sv
`timescale 1ns / 1ps

module iwt_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iwt_pkg::cmd_t                 cmd_i,
  input  logic [iwt_pkg::ValueW-1:0]    value_i,
  input  logic                          out_ready_i,
  output iwt_pkg::status_t              status_o,
  output logic                          out_valid_o,
  output logic [iwt_pkg::CodeW-1:0]     word_code_o,
  output logic                          last_word_o
);

  logic [iwt_pkg::ValueW-1:0]   bin_q;
  logic [iwt_pkg::BcdW-1:0]     bcd_q;
  logic [iwt_pkg::BcdW-1:0]     bcd_adj;
  logic [iwt_pkg::ConvCntW-1:0] cnt_q;
  iwt_pkg::group_e              grp_q;
  iwt_pkg::phase_e              ph_q;
  logic                         pend_valid_q, pend_valid_d;
  logic [iwt_pkg::CodeW-1:0]    pend_code_q;
  logic                         out_valid_q, out_valid_d;
  logic [iwt_pkg::CodeW-1:0]    out_code_q;
  logic                         out_last_q;

  logic [iwt_pkg::DigitW-1:0]   dig_h, dig_t, dig_o;
  logic                         grp_nz;
  logic                         tok_valid;
  logic [iwt_pkg::CodeW-1:0]    tok_code;
  logic [iwt_pkg::CodeW-1:0]    scale_code;
  logic                         take_tok;
  logic                         push_pend;
  logic                         slot_free;

  // add three to every digit above four, then shift in the next bit
  always_comb begin
    for (int i = 0; i < iwt_pkg::NumDigits; i++) begin
      if (bcd_q[i*iwt_pkg::DigitW +: iwt_pkg::DigitW] >= 4'd5) begin
        bcd_adj[i*iwt_pkg::DigitW +: iwt_pkg::DigitW] =
          bcd_q[i*iwt_pkg::DigitW +: iwt_pkg::DigitW] + 4'd3;
      end else begin
        bcd_adj[i*iwt_pkg::DigitW +: iwt_pkg::DigitW] =
          bcd_q[i*iwt_pkg::DigitW +: iwt_pkg::DigitW];
      end
    end
  end

  always_comb begin
    dig_h      = '0;
    dig_t      = '0;
    dig_o      = '0;
    scale_code = iwt_pkg::WORD_ZERO;
    unique case (grp_q)
      iwt_pkg::GRP_BILLION: begin
        dig_o      = bcd_q[39:36];
        scale_code = iwt_pkg::WORD_BILLION;
      end
      iwt_pkg::GRP_MILLION: begin
        dig_h      = bcd_q[35:32];
        dig_t      = bcd_q[31:28];
        dig_o      = bcd_q[27:24];
        scale_code = iwt_pkg::WORD_MILLION;
      end
      iwt_pkg::GRP_THOUSAND: begin
        dig_h      = bcd_q[23:20];
        dig_t      = bcd_q[19:16];
        dig_o      = bcd_q[15:12];
        scale_code = iwt_pkg::WORD_THOUSAND;
      end
      iwt_pkg::GRP_UNIT: begin
        dig_h = bcd_q[11:8];
        dig_t = bcd_q[7:4];
        dig_o = bcd_q[3:0];
      end
      default: begin
        dig_h = '0;
      end
    endcase
  end

  assign grp_nz = (dig_h != '0) || (dig_t != '0) || (dig_o != '0);

  always_comb begin
    tok_valid = 1'b0;
    tok_code  = iwt_pkg::WORD_ZERO;
    unique case (ph_q)
      iwt_pkg::PH_DIGIT: begin
        tok_valid = dig_h != '0;
        tok_code  = {1'b0, dig_h};
      end
      iwt_pkg::PH_HUNDRED: begin
        tok_valid = dig_h != '0;
        tok_code  = iwt_pkg::WORD_HUNDRED;
      end
      iwt_pkg::PH_TENS: begin
        priority if (dig_t >= 4'd2) begin
          tok_valid = 1'b1;
          tok_code  = iwt_pkg::WORD_TENS_BASE + {1'b0, dig_t};
        end else if (dig_t == 4'd1) begin
          tok_valid = 1'b1;
          tok_code  = iwt_pkg::WORD_TEEN_BASE + {1'b0, dig_o};
        end else begin
          tok_valid = dig_o != '0;
          tok_code  = {1'b0, dig_o};
        end
      end
      iwt_pkg::PH_ONES: begin
        tok_valid = (dig_t >= 4'd2) && (dig_o != '0);
        tok_code  = {1'b0, dig_o};
      end
      iwt_pkg::PH_SCALE: begin
        tok_valid = grp_nz && (grp_q != iwt_pkg::GRP_UNIT);
        tok_code  = scale_code;
      end
      default: begin
        tok_valid = 1'b0;
      end
    endcase
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign take_tok  = cmd_i.emit_step && tok_valid;
  assign push_pend = take_tok && pend_valid_q;

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (cmd_i.load || cmd_i.flush) begin
      pend_valid_d = 1'b0;
    end else if (take_tok) begin
      pend_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (push_pend || cmd_i.flush) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      grp_q        <= iwt_pkg::GRP_BILLION;
      ph_q         <= iwt_pkg::PH_DIGIT;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cmd_i.load) begin
        cnt_q <= '0;
        grp_q <= iwt_pkg::GRP_BILLION;
        ph_q  <= iwt_pkg::PH_DIGIT;
      end else begin
        if (cmd_i.conv_step) cnt_q <= cnt_q + 1'b1;
        if (cmd_i.emit_step) begin
          unique case (ph_q)
            iwt_pkg::PH_DIGIT:   ph_q <= iwt_pkg::PH_HUNDRED;
            iwt_pkg::PH_HUNDRED: ph_q <= iwt_pkg::PH_TENS;
            iwt_pkg::PH_TENS:    ph_q <= iwt_pkg::PH_ONES;
            iwt_pkg::PH_ONES:    ph_q <= iwt_pkg::PH_SCALE;
            iwt_pkg::PH_SCALE: begin
              ph_q <= iwt_pkg::PH_DIGIT;
              unique case (grp_q)
                iwt_pkg::GRP_BILLION:  grp_q <= iwt_pkg::GRP_MILLION;
                iwt_pkg::GRP_MILLION:  grp_q <= iwt_pkg::GRP_THOUSAND;
                iwt_pkg::GRP_THOUSAND: grp_q <= iwt_pkg::GRP_UNIT;
                iwt_pkg::GRP_UNIT:     grp_q <= iwt_pkg::GRP_UNIT;
                default:               grp_q <= iwt_pkg::GRP_BILLION;
              endcase
            end
            default: ph_q <= iwt_pkg::PH_DIGIT;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (cmd_i.conv_step) begin
      bin_q <= {bin_q[iwt_pkg::ValueW-2:0], 1'b0};
      bcd_q <= {bcd_adj[iwt_pkg::BcdW-2:0], bin_q[iwt_pkg::ValueW-1]};
    end
    if (take_tok) pend_code_q <= tok_code;
    if (push_pend) begin
      out_code_q <= pend_code_q;
      out_last_q <= 1'b0;
    end else if (cmd_i.flush) begin
      out_code_q <= pend_valid_q ? pend_code_q : iwt_pkg::WORD_ZERO;
      out_last_q <= 1'b1;
    end
  end

  assign status_o.conv_done  = cnt_q == iwt_pkg::ConvLast;
  assign status_o.emit_done  = (grp_q == iwt_pkg::GRP_UNIT) && (ph_q == iwt_pkg::PH_SCALE);
  assign status_o.slot_free  = slot_free;
  assign status_o.pend_valid = pend_valid_q;

  assign out_valid_o = out_valid_q;
  assign word_code_o = out_code_q;
  assign last_word_o = out_last_q;

endmodule

>>> sv/integer_to_word_tokens.sv
`timescale 1ns / 1ps

// channel  | dir | payload                       | word
// in_i     | in  | value[30:0]                   | one integer
// out_o    | out | word_code[4:0], last_word     | one word token, last flagged
//
// A value is taken only while the block is idle. A shift-add-3 binary to
// decimal converter shifts in every bit of the value, then the token walker steps 20 slots
// (four groups of five), one per cycle while the output register is free,
// and a flush step emits the last token.
// Reset clears the controller, the walker and the valid flags.
// A stalled output register holds the walker; tokens are never dropped.

module integer_to_word_tokens (
  input  logic             clk_i,
  input  logic             rst_ni,
  iwt_in_if.sink           in_i,
  iwt_out_if.source        out_o
);

  iwt_pkg::cmd_t    cmd;
  iwt_pkg::status_t status;
  logic             in_ready;
  logic             out_valid;
  logic [iwt_pkg::CodeW-1:0] out_code;
  logic             out_last;

  iwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  iwt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (in_i.value),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (out_valid),
    .word_code_o (out_code),
    .last_word_o (out_last)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.word_code = out_code;
  assign out_o.last_word = out_last;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !status.pend_valid)
    else $error("pending token left over while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.conv_step)
    else $error("conversion did not start after load");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_step || cmd.flush) |-> status.slot_free)
    else $error("walker advanced while output register was stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.conv_step, cmd.emit_step, cmd.flush}))
    else $error("conflicting datapath commands");
`endif

endmodule
